// ===== hw/rtl/sdspi_pkg.sv =====
// Shared types, codes and helper functions for the SD card SPI-mode sequencer.
// Used by sdspi_seq and sd_spi_init_and_block_read_core; no dependencies.
package sdspi_pkg;

  localparam int unsigned BlockBytes = 512;
  localparam int unsigned CntW = 10;

  typedef enum logic [1:0] {
    CMD_INIT = 2'd0,
    CMD_READ = 2'd1,
    CMD_BYTE = 2'd2,
    CMD_TICK = 2'd3
  } cmd_e;

  typedef enum logic [3:0] {
    PH_IDLE    = 4'd0,
    PH_START   = 4'd1,
    PH_FRAME   = 4'd2,
    PH_POLL    = 4'd3,
    PH_TAIL    = 4'd4,
    PH_END     = 4'd5,
    PH_TOKEN   = 4'd6,
    PH_DATA    = 4'd7,
    PH_DCRC    = 4'd8,
    PH_END_TMO = 4'd9
  } phase_e;

  typedef enum logic [3:0] {
    ST_OK      = 4'd0,
    ST_NOCARD  = 4'd1,
    ST_CMD0    = 4'd2,
    ST_CMD8    = 4'd3,
    ST_CMD55   = 4'd4,
    ST_ACMD41  = 4'd5,
    ST_TIMEOUT = 4'd6,
    ST_CMD58   = 4'd7,
    ST_NOINIT  = 4'd8,
    ST_CMD17   = 4'd9
  } status_e;

  // Register indexes on the configuration port.
  localparam logic [1:0] RegDummy   = 2'd0;
  localparam logic [1:0] RegPoll    = 2'd1;
  localparam logic [1:0] RegInitTmo = 2'd2;
  localparam logic [1:0] RegReadTmo = 2'd3;

  // Command indexes.
  localparam logic [5:0] Cmd0  = 6'd0;
  localparam logic [5:0] Cmd8  = 6'd8;
  localparam logic [5:0] Cmd17 = 6'd17;
  localparam logic [5:0] Cmd41 = 6'd41;
  localparam logic [5:0] Cmd55 = 6'd55;
  localparam logic [5:0] Cmd58 = 6'd58;

  localparam logic [31:0] ArgCmd8  = 32'h0000_01AA;
  localparam logic [31:0] ArgAcmd41 = 32'h4000_0000;
  localparam logic [7:0]  TokenStart = 8'hFE;
  localparam logic [7:0]  ByteIdle   = 8'hFF;

  // One result beat.
  typedef struct packed {
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       select_active;
    logic       data_valid;
    logic [7:0] data_byte;
    logic       done_res;
    logic [3:0] status;
  } res_t;

  // CRC7 (polynomial 0x09) advanced by one byte, most significant bit first.
  function automatic logic [6:0] crc7_byte(input logic [6:0] crc, input logic [7:0] b);
    logic [6:0] c;
    logic       mix;
    c = crc;
    for (int k = 0; k < 8; k++) begin
      mix = c[6] ^ b[7-k];
      c   = {c[5:0], 1'b0};
      if (mix) begin
        c = c ^ 7'h09;
      end
    end
    return c;
  endfunction

  // Expected R7 trailer bytes for CMD8.
  function automatic logic [7:0] r7_expect(input logic [1:0] i);
    logic [7:0] v;
    case (i)
      2'd2:    v = 8'h01;
      2'd3:    v = 8'hAA;
      default: v = 8'h00;
    endcase
    return v;
  endfunction

endpackage

// ===== hw/rtl/sdspi_seq.sv =====
// Sequencer state and single-step logic of the SD card SPI-mode host.
// Depends on sdspi_pkg for phases, codes, the result struct and CRC7.
module sdspi_seq (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [1:0]        cfg_idx_i,
  input  logic [15:0]       cfg_data_i,
  input  logic              step_i,
  input  logic [1:0]        cmd_i,
  input  logic [31:0]       block_index_i,
  input  logic [7:0]        rx_byte_i,
  input  logic              card_present_i,
  output logic              has_res_o,
  output sdspi_pkg::res_t   res_o
);
  import sdspi_pkg::*;

  logic [7:0]  dummy_q, poll_lim_q;
  logic [15:0] init_tmo_q, read_tmo_q;

  phase_e      ph_q, ph_d;
  logic        init_q, init_d, hc_q, hc_d, mism_q, mism_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [7:0]  poll_q, poll_d, resp_q, resp_d;
  logic [15:0] ms_q, ms_d;
  logic [31:0] arg_q, arg_d;
  logic [5:0]  idx_q, idx_d;
  logic [6:0]  crc_q, crc_d;

  res_t        res;
  logic        sf_go, ar_go, fin_go;
  logic [5:0]  sf_idx;
  logic [31:0] sf_arg;
  logic [3:0]  fin_st;
  logic [CntW-1:0] cnt_inc;
  logic [7:0]  fbyte;
  logic [7:0]  ar_resp;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dummy_q    <= 8'd10;
      poll_lim_q <= 8'd16;
      init_tmo_q <= 16'd1000;
      read_tmo_q <= 16'd1000;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegDummy:   dummy_q    <= cfg_data_i[7:0];
        RegPoll:    poll_lim_q <= cfg_data_i[7:0];
        RegInitTmo: init_tmo_q <= cfg_data_i;
        RegReadTmo: read_tmo_q <= cfg_data_i;
        default:    ;
      endcase
    end
  end

  // Sequencer state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q   <= PH_IDLE;
      init_q <= 1'b0;
      hc_q   <= 1'b0;
      mism_q <= 1'b0;
      cnt_q  <= '0;
      poll_q <= '0;
      resp_q <= ByteIdle;
      ms_q   <= '0;
      arg_q  <= '0;
      idx_q  <= '0;
      crc_q  <= '0;
    end else if (step_i) begin
      ph_q   <= ph_d;
      init_q <= init_d;
      hc_q   <= hc_d;
      mism_q <= mism_d;
      cnt_q  <= cnt_d;
      poll_q <= poll_d;
      resp_q <= resp_d;
      ms_q   <= ms_d;
      arg_q  <= arg_d;
      idx_q  <= idx_d;
      crc_q  <= crc_d;
    end
  end

  assign cnt_inc = cnt_q + 1'b1;

  // Frame byte for the incremented count: argument bytes, then CRC with stop bit.
  always_comb begin
    case (cnt_inc[2:0])
      3'd1:    fbyte = arg_q[31:24];
      3'd2:    fbyte = arg_q[23:16];
      3'd3:    fbyte = arg_q[15:8];
      3'd4:    fbyte = arg_q[7:0];
      default: fbyte = {crc_q, 1'b1};
    endcase
  end

  // One step of the sequencer for the current beat.
  always_comb begin
    ph_d   = ph_q;
    init_d = init_q;
    hc_d   = hc_q;
    mism_d = mism_q;
    cnt_d  = cnt_q;
    poll_d = poll_q;
    resp_d = resp_q;
    ms_d   = ms_q;
    arg_d  = arg_q;
    idx_d  = idx_q;
    crc_d  = crc_q;
    res    = '0;
    sf_go  = 1'b0;
    sf_idx = Cmd0;
    sf_arg = '0;
    ar_go  = 1'b0;
    ar_resp = ByteIdle;
    fin_go = 1'b0;
    fin_st = ST_OK;

    case (cmd_i)
      CMD_TICK: begin
        if (ph_q != PH_IDLE && ms_q != 16'hFFFF) begin
          ms_d = ms_q + 16'd1;
        end
      end
      CMD_INIT: begin
        if (ph_q == PH_IDLE) begin
          if (!card_present_i) begin
            fin_go = 1'b1; fin_st = ST_NOCARD;
          end else if (dummy_q == 8'd0) begin
            sf_go = 1'b1; sf_idx = Cmd0; sf_arg = '0;
          end else begin
            cnt_d = CntW'(1);
            ph_d  = PH_START;
            res.tx_valid = 1'b1; res.tx_byte = ByteIdle;
          end
        end
      end
      CMD_READ: begin
        if (ph_q == PH_IDLE) begin
          if (!init_q) begin
            fin_go = 1'b1; fin_st = ST_NOINIT;
          end else begin
            sf_go  = 1'b1; sf_idx = Cmd17;
            sf_arg = hc_q ? block_index_i : {block_index_i[22:0], 9'd0};
          end
        end
      end
      default: begin
        case (ph_q)
          PH_START: begin
            if (cnt_q >= CntW'(dummy_q)) begin
              sf_go = 1'b1; sf_idx = Cmd0; sf_arg = '0;
            end else begin
              cnt_d = cnt_inc;
              res.tx_valid = 1'b1; res.tx_byte = ByteIdle;
            end
          end
          PH_FRAME: begin
            cnt_d = cnt_inc;
            if (cnt_inc < CntW'(6)) begin
              res.tx_valid = 1'b1; res.tx_byte = fbyte; res.select_active = 1'b1;
              if (cnt_inc < CntW'(5)) begin
                crc_d = crc7_byte(crc_q, fbyte);
              end
            end else if (poll_lim_q == 8'd0) begin
              ar_go = 1'b1; ar_resp = ByteIdle;
            end else begin
              poll_d = 8'd1;
              ph_d   = PH_POLL;
              res.tx_valid = 1'b1; res.tx_byte = ByteIdle; res.select_active = 1'b1;
            end
          end
          PH_POLL: begin
            if (!rx_byte_i[7]) begin
              ar_go = 1'b1; ar_resp = rx_byte_i;
            end else if (poll_q >= poll_lim_q) begin
              ar_go = 1'b1; ar_resp = ByteIdle;
            end else begin
              poll_d = poll_q + 8'd1;
              res.tx_valid = 1'b1; res.tx_byte = ByteIdle; res.select_active = 1'b1;
            end
          end
          PH_TAIL: begin
            if (idx_q == Cmd8) begin
              if (rx_byte_i != r7_expect(cnt_q[1:0])) begin
                mism_d = 1'b1;
              end
            end else if (cnt_q == '0) begin
              hc_d = rx_byte_i[6];
            end
            cnt_d = cnt_inc;
            res.tx_valid = 1'b1; res.tx_byte = ByteIdle;
            if (cnt_inc >= CntW'(4)) begin
              ph_d = PH_END;
            end else begin
              res.select_active = 1'b1;
            end
          end
          PH_END: begin
            case (idx_q)
              Cmd0: begin
                if (resp_q == 8'h01) begin
                  mism_d = 1'b0;
                  sf_go = 1'b1; sf_idx = Cmd8; sf_arg = ArgCmd8;
                end else begin
                  fin_go = 1'b1; fin_st = ST_CMD0;
                end
              end
              Cmd8: begin
                if (resp_q != 8'h01 || mism_q) begin
                  fin_go = 1'b1; fin_st = ST_CMD8;
                end else begin
                  ms_d  = '0;
                  sf_go = 1'b1; sf_idx = Cmd55; sf_arg = '0;
                end
              end
              Cmd55: begin
                if (resp_q != 8'h00 && resp_q != 8'h01) begin
                  fin_go = 1'b1; fin_st = ST_CMD55;
                end else begin
                  sf_go = 1'b1; sf_idx = Cmd41; sf_arg = ArgAcmd41;
                end
              end
              Cmd41: begin
                if (resp_q == 8'h00) begin
                  sf_go = 1'b1; sf_idx = Cmd58; sf_arg = '0;
                end else if (resp_q != 8'h01) begin
                  fin_go = 1'b1; fin_st = ST_ACMD41;
                end else if (ms_q > init_tmo_q) begin
                  fin_go = 1'b1; fin_st = ST_TIMEOUT;
                end else begin
                  sf_go = 1'b1; sf_idx = Cmd55; sf_arg = '0;
                end
              end
              Cmd58: begin
                fin_go = 1'b1;
                if (resp_q != 8'h00) begin
                  fin_st = ST_CMD58;
                end else begin
                  init_d = 1'b1; fin_st = ST_OK;
                end
              end
              default: begin
                fin_go = 1'b1;
                fin_st = (resp_q != 8'h00) ? ST_CMD17 : ST_OK;
              end
            endcase
          end
          PH_TOKEN: begin
            res.tx_valid = 1'b1; res.tx_byte = ByteIdle;
            if (ms_q > read_tmo_q) begin
              ph_d = PH_END_TMO;
            end else begin
              res.select_active = 1'b1;
              if (rx_byte_i == TokenStart) begin
                cnt_d = '0; ph_d = PH_DATA;
              end
            end
          end
          PH_DATA: begin
            res.data_valid = 1'b1; res.data_byte = rx_byte_i;
            res.tx_valid = 1'b1; res.tx_byte = ByteIdle; res.select_active = 1'b1;
            if (cnt_inc >= CntW'(BlockBytes - 1) + CntW'(1) || cnt_inc == '0) begin
              cnt_d = '0; ph_d = PH_DCRC;
            end else begin
              cnt_d = cnt_inc;
            end
          end
          PH_DCRC: begin
            cnt_d = cnt_inc;
            res.tx_valid = 1'b1; res.tx_byte = ByteIdle;
            if (cnt_inc >= CntW'(2)) begin
              ph_d = PH_END;
            end else begin
              res.select_active = 1'b1;
            end
          end
          PH_END_TMO: begin
            fin_go = 1'b1; fin_st = ST_TIMEOUT;
          end
          default: ;
        endcase
      end
    endcase

    // Handling of an R1 reply: move to the trailer, the token wait or the end byte.
    if (ar_go) begin
      resp_d = ar_resp;
      res.tx_valid = 1'b1; res.tx_byte = ByteIdle; res.select_active = 1'b1;
      if ((idx_q == Cmd8 && ar_resp == 8'h01) || (idx_q == Cmd58 && ar_resp == 8'h00)) begin
        cnt_d = '0; ph_d = PH_TAIL;
      end else if (idx_q == Cmd17 && ar_resp == 8'h00) begin
        ms_d = '0; ph_d = PH_TOKEN;
      end else begin
        ph_d = PH_END; res.select_active = 1'b0;
      end
    end

    // Start of a command frame: first byte goes out now, CRC runs over the command and argument bytes.
    if (sf_go) begin
      idx_d = sf_idx;
      arg_d = sf_arg;
      crc_d = crc7_byte(7'd0, {2'b01, sf_idx});
      cnt_d = '0;
      ph_d  = PH_FRAME;
      res.tx_valid = 1'b1; res.tx_byte = {2'b01, sf_idx}; res.select_active = 1'b1;
    end

    // Operation finished.
    if (fin_go) begin
      ph_d = PH_IDLE;
      res.done_res = 1'b1;
      res.status = fin_st;
    end
  end

  assign res_o     = res;
  assign has_res_o = res.tx_valid | res.done_res;

endmodule

// ===== hw/rtl/sd_spi_init_and_block_read_core.sv =====
// Top level of the SD card SPI-mode host sequencer: input register, step logic, result register.
// Depends on sdspi_pkg and sdspi_seq.

// Each beat in is one command, one received byte or one millisecond tick; each beat out asks
// the byte exchanger for one transfer, hands over one block byte, or reports the end of an
// operation with its status. The block takes one beat per clock unless stalled: a beat is
// registered, passes through one step of the sequencer (the byte-wise CRC7 update is the longest
// path) and its result lands in the output register. The input stalls only while the output
// register is full and stalled. Configuration must be written through cfg_we_i, cfg_idx_i and
// cfg_data_i only while the block is idle; the block itself does not enforce this.
module sd_spi_init_and_block_read_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  cmd_i,
  input  logic [31:0] block_index_i,
  input  logic [7:0]  rx_byte_i,
  input  logic        card_present_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        tx_valid_o,
  output logic [7:0]  tx_byte_o,
  output logic        select_active_o,
  output logic        data_valid_o,
  output logic [7:0]  data_byte_o,
  output logic        done_res_o,
  output logic [3:0]  status_o
);
  import sdspi_pkg::*;

  logic        iv_q;
  logic [1:0]  cmd_q;
  logic [31:0] blk_q;
  logic [7:0]  rx_q;
  logic        pres_q;
  logic        ov_q;
  res_t        res_q, res;
  logic        has_res, adv, step;

  // The held beat moves on when the output register is free or being emptied.
  assign adv        = !ov_q || !out_stall_i;
  assign step       = iv_q && adv;
  assign in_stall_o = iv_q && !adv;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      iv_q <= 1'b0;
    end else if (!in_stall_o) begin
      iv_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      cmd_q  <= cmd_i;
      blk_q  <= block_index_i;
      rx_q   <= rx_byte_i;
      pres_q <= card_present_i;
    end
  end

  sdspi_seq u_seq (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .step_i         (step),
    .cmd_i          (cmd_q),
    .block_index_i  (blk_q),
    .rx_byte_i      (rx_q),
    .card_present_i (pres_q),
    .has_res_o      (has_res),
    .res_o          (res)
  );

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (adv) begin
      ov_q <= step && has_res;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && has_res) begin
      res_q <= res;
    end
  end

  assign out_valid_o     = ov_q;
  assign tx_valid_o      = res_q.tx_valid;
  assign tx_byte_o       = res_q.tx_byte;
  assign select_active_o = res_q.select_active;
  assign data_valid_o    = res_q.data_valid;
  assign data_byte_o     = res_q.data_byte;
  assign done_res_o      = res_q.done_res;
  assign status_o        = res_q.status;

endmodule
